// ----- rtl/tlef_pkg.sv -----
// ----------------------------------------------------------------------------
// Text line number and escape filter: shared definitions
// Character codes, register indexes, configuration and work descriptor types.
// ----------------------------------------------------------------------------
package tlef_pkg;

    // Default number of decimal digits in the line number.
    localparam int LINE_DIGITS_DEF = 6;
    // Default depth of the descriptor queue between front and back.
    localparam int DESC_DEPTH_DEF = 4;
    // Depth of the result queue that drives the output ports.
    localparam int OUT_DEPTH = 2;

    // Configuration register map.
    localparam int NUM_CFG = 6;
    localparam int CFG_ADDR_W = $clog2(NUM_CFG * 4);
    localparam int CFG_IDX_W = CFG_ADDR_W - 2;
    localparam int PDATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUMBER_NONBLANK  = 3'd0,
        CFG_NUMBER_ALL       = 3'd1,
        CFG_SQUEEZE_BLANK    = 3'd2,
        CFG_SHOW_ENDS        = 3'd3,
        CFG_SHOW_TABS        = 3'd4,
        CFG_SHOW_NONPRINTING = 3'd5
    } t_cfg_idx;

    // Character codes.
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] CH_I        = 8'h49;
    localparam logic [7:0] CH_CARET    = 8'h5E;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CTRL_MAX    = 8'd31;
    localparam logic [7:0] CTRL_OFFSET = 8'd64;

    localparam logic [3:0] BCD_NINE = 4'd9;

    // Mode flags as seen by the front.
    typedef struct packed {
        logic number_nonblank;
        logic number_all;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    // Control part of one work descriptor; the line number digits and the
    // blank mask travel beside it.
    typedef struct packed {
        logic       lead;    // digits (or blank padding) and a tab come first
        logic       dollar;  // a dollar sign before the character
        logic       caret;   // a caret before the character
        logic [7:0] ch;      // final character of the transaction
    } t_desc;

endpackage

// ----- rtl/tlef_queue.sv -----
// ----------------------------------------------------------------------------
// Text line number and escape filter: small queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module tlef_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);

    a_push_not_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue written while full");

    a_pop_not_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue read while empty");

endmodule

// ----- rtl/tlef_front.sv -----
// ----------------------------------------------------------------------------
// Text line number and escape filter: front
// Classifies each input byte, keeps line state and the line counter, and
// writes one descriptor per byte that produces output.
// ----------------------------------------------------------------------------
module tlef_front #(
    parameter int LINE_DIGITS = tlef_pkg::LINE_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tlef_pkg::t_cfg               i_cfg,
    input  logic                         i_acc,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_file_start,
    output logic                         o_push,
    output tlef_pkg::t_desc              o_desc,
    output logic [LINE_DIGITS-1:0][3:0]  o_digits,
    output logic [LINE_DIGITS-1:0]       o_blank
);

    logic                        r_prev_nl, n_prev_nl;
    logic                        r_seen, n_seen;
    logic [LINE_DIGITS-1:0][3:0] r_cnt, n_cnt;
    logic [LINE_DIGITS-1:0][3:0] cnt_one;
    logic [LINE_DIGITS-1:0][3:0] cnt_cur;
    logic [LINE_DIGITS-1:0][3:0] cnt_inc;
    logic [LINE_DIGITS:0]        carry;
    logic [LINE_DIGITS-1:0]      lead_zero;
    logic                        past_nl;
    logic                        seen_cur;
    logic                        now_nl;
    logic                        drop;
    logic                        num;
    logic                        pad;
    logic                        is_ctrl;
    logic                        tab_shown;

    always_comb begin
        cnt_one    = '0;
        cnt_one[0] = 4'd1;
    end

    assign past_nl  = i_file_start | r_prev_nl;
    assign seen_cur = !i_file_start & r_seen;
    assign cnt_cur  = i_file_start ? cnt_one : r_cnt;
    assign now_nl   = (i_data_byte == tlef_pkg::CH_NL);
    assign drop     = i_cfg.squeeze_blank & now_nl & past_nl & seen_cur;

    // Decimal increment: a digit steps when every lower digit is nine.
    // The counter holds once all digits are nine.
    always_comb begin
        carry[0] = 1'b1;
        for (int i = 0; i < LINE_DIGITS; i++) begin
            carry[i+1] = carry[i] & (cnt_cur[i] == tlef_pkg::BCD_NINE);
        end
        for (int i = 0; i < LINE_DIGITS; i++) begin
            if (carry[LINE_DIGITS] || !carry[i]) begin
                cnt_inc[i] = cnt_cur[i];
            end else if (cnt_cur[i] == tlef_pkg::BCD_NINE) begin
                cnt_inc[i] = 4'd0;
            end else begin
                cnt_inc[i] = cnt_cur[i] + 4'd1;
            end
        end
    end

    // Leading zeros are shown as spaces; the lowest digit always shows.
    always_comb begin
        lead_zero = '0;
        for (int i = LINE_DIGITS - 1; i > 0; i--) begin
            if (i == LINE_DIGITS - 1) begin
                lead_zero[i] = (cnt_cur[i] == 4'd0);
            end else begin
                lead_zero[i] = lead_zero[i+1] & (cnt_cur[i] == 4'd0);
            end
        end
    end

    always_comb begin
        if (i_cfg.number_nonblank) begin
            num = past_nl & !now_nl;
        end else begin
            num = i_cfg.number_all & past_nl;
        end
        pad       = i_cfg.show_ends & now_nl & i_cfg.number_nonblank & past_nl;
        tab_shown = i_cfg.show_tabs & (i_data_byte == tlef_pkg::CH_TAB);
        is_ctrl   = (i_data_byte <= tlef_pkg::CTRL_MAX) &&
                    (i_data_byte != tlef_pkg::CH_TAB) && (i_data_byte != tlef_pkg::CH_NL);

        o_desc.lead   = num | pad;
        o_desc.dollar = i_cfg.show_ends & now_nl;
        o_desc.caret  = tab_shown |
                        (i_cfg.show_nonprinting &
                         (is_ctrl | (i_data_byte == tlef_pkg::CH_DEL)));
        if (tab_shown) begin
            o_desc.ch = tlef_pkg::CH_I;
        end else if (i_cfg.show_nonprinting && is_ctrl) begin
            o_desc.ch = i_data_byte + tlef_pkg::CTRL_OFFSET;
        end else if (i_cfg.show_nonprinting && (i_data_byte == tlef_pkg::CH_DEL)) begin
            o_desc.ch = tlef_pkg::CH_QMARK;
        end else begin
            o_desc.ch = i_data_byte;
        end
        o_digits = cnt_cur;
        o_blank  = pad ? '1 : lead_zero;
        o_push   = i_acc & !drop;
    end

    always_comb begin
        n_prev_nl = r_prev_nl;
        n_seen    = r_seen;
        n_cnt     = r_cnt;
        if (i_acc) begin
            n_prev_nl = now_nl;
            if (i_cfg.squeeze_blank) begin
                n_seen = now_nl & past_nl;
            end else begin
                n_seen = seen_cur;
            end
            n_cnt = (!drop && num) ? cnt_inc : cnt_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_nl <= 1'b1;
            r_seen    <= 1'b0;
            r_cnt     <= cnt_one;
        end else begin
            r_prev_nl <= n_prev_nl;
            r_seen    <= n_seen;
            r_cnt     <= n_cnt;
        end
    end

    a_drop_keeps_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && drop && !i_file_start) |=> (r_cnt == $past(r_cnt)))
        else $error("dropped newline changed the line counter");

endmodule

// ----- rtl/tlef_back.sv -----
// ----------------------------------------------------------------------------
// Text line number and escape filter: back
// Expands each descriptor into its output bytes, one byte per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module tlef_back #(
    parameter int LINE_DIGITS = tlef_pkg::LINE_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_desc_valid,
    input  tlef_pkg::t_desc              i_desc,
    input  logic [LINE_DIGITS-1:0][3:0]  i_digits,
    input  logic [LINE_DIGITS-1:0]       i_blank,
    input  logic                         i_out_full,
    output logic                         o_desc_pop,
    output logic                         o_emit,
    output logic [7:0]                   o_byte,
    output logic                         o_last
);

    localparam int POS_W = (LINE_DIGITS > 1) ? $clog2(LINE_DIGITS) : 1;

    typedef enum logic [4:0] {
        ST_DIGIT  = 5'b00001,
        ST_TAB    = 5'b00010,
        ST_DOLLAR = 5'b00100,
        ST_CARET  = 5'b01000,
        ST_CHAR   = 5'b10000
    } t_bstate;

    logic                        r_busy, n_busy;
    t_bstate                     r_state, n_state;
    logic [POS_W-1:0]            r_pos, n_pos;
    tlef_pkg::t_desc             r_desc;
    logic [LINE_DIGITS-1:0][3:0] r_digits;
    logic [LINE_DIGITS-1:0]      r_blank;
    logic                        load;
    t_bstate                     first_state;
    t_bstate                     after_tab;

    assign o_emit     = r_busy & !i_out_full;
    assign o_last     = (r_state == ST_CHAR);
    assign load       = i_desc_valid & (!r_busy | (o_emit & o_last));
    assign o_desc_pop = load;

    always_comb begin
        if (i_desc.lead) begin
            first_state = ST_DIGIT;
        end else if (i_desc.dollar) begin
            first_state = ST_DOLLAR;
        end else if (i_desc.caret) begin
            first_state = ST_CARET;
        end else begin
            first_state = ST_CHAR;
        end
        if (r_desc.dollar) begin
            after_tab = ST_DOLLAR;
        end else if (r_desc.caret) begin
            after_tab = ST_CARET;
        end else begin
            after_tab = ST_CHAR;
        end
    end

    always_comb begin
        unique case (r_state)
            ST_DIGIT: begin
                o_byte = r_blank[r_pos] ? tlef_pkg::CH_SPACE
                                        : tlef_pkg::CH_ZERO + {4'b0000, r_digits[r_pos]};
            end
            ST_TAB:    o_byte = tlef_pkg::CH_TAB;
            ST_DOLLAR: o_byte = tlef_pkg::CH_DOLLAR;
            ST_CARET:  o_byte = tlef_pkg::CH_CARET;
            ST_CHAR:   o_byte = r_desc.ch;
            default:   o_byte = r_desc.ch;
        endcase
    end

    always_comb begin
        n_busy  = r_busy;
        n_state = r_state;
        n_pos   = r_pos;
        if (load) begin
            n_busy  = 1'b1;
            n_state = first_state;
            n_pos   = POS_W'(LINE_DIGITS - 1);
        end else if (o_emit) begin
            unique case (r_state)
                ST_DIGIT: begin
                    if (r_pos == '0) begin
                        n_state = ST_TAB;
                    end else begin
                        n_pos = r_pos - 1'b1;
                    end
                end
                ST_TAB:    n_state = after_tab;
                ST_DOLLAR: n_state = r_desc.caret ? ST_CARET : ST_CHAR;
                ST_CARET:  n_state = ST_CHAR;
                ST_CHAR:   n_busy  = 1'b0;
                default:   n_busy  = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_state <= ST_CHAR;
            r_pos   <= '0;
        end else begin
            r_busy  <= n_busy;
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc   <= i_desc;
            r_digits <= i_digits;
            r_blank  <= i_blank;
        end
    end

    a_digits_end_in_tab : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && !load && (r_state == ST_DIGIT) && (r_pos == '0)) |=> (r_state == ST_TAB))
        else $error("line number not followed by a tab");

    a_no_load_midway : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_state != ST_CHAR)) |-> !o_desc_pop)
        else $error("descriptor taken before the previous one finished");

endmodule

// ----- rtl/text_line_number_and_escape_filter_top.sv -----
// ----------------------------------------------------------------------------
// Text line number and escape filter: top level
// Line numbering, blank squeezing, end marking and caret escaping of a byte stream.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  input     push / full           i_data_byte, i_file_start
//  result    empty / pop           o_out_byte, o_last_of_run
//  config    psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
//  Each input byte becomes one to LINE_DIGITS+3 output bytes, or none for a
//  squeezed newline. While the result queue has room, the back writes one
//  output byte per cycle and takes no new descriptor before the last byte of
//  the current one, so a plain byte stream runs at one transaction per cycle.
//  The descriptor queue (DESC_DEPTH entries) lets the front keep accepting
//  while the back expands a line number; full rises once it is filled.
//  Reset is synchronous, active low, and returns the line state and the mode
//  registers to their initial values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module text_line_number_and_escape_filter_top #(
    parameter int LINE_DIGITS = tlef_pkg::LINE_DIGITS_DEF,
    parameter int DESC_DEPTH  = tlef_pkg::DESC_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input queue side.
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_file_start,
    // Result queue side.
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last_of_run,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlef_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tlef_pkg::PDATA_W-1:0]    pwdata,
    output logic [tlef_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    localparam int DESC_W = $bits(tlef_pkg::t_desc);
    localparam int DQ_W   = 4 * LINE_DIGITS + LINE_DIGITS + DESC_W;

    // Mode registers.
    tlef_pkg::t_cfg                r_cfg;
    logic                          cfg_wr;
    logic [tlef_pkg::CFG_IDX_W-1:0] cfg_idx;

    // Front to descriptor queue.
    logic                          in_acc;
    logic                          f_push;
    tlef_pkg::t_desc               f_desc;
    logic [LINE_DIGITS-1:0][3:0]   f_digits;
    logic [LINE_DIGITS-1:0]        f_blank;
    logic [DQ_W-1:0]               dq_wdata;
    logic [DQ_W-1:0]               dq_rdata;
    logic                          dq_full;
    logic                          dq_empty;

    // Back to result queue.
    logic                          b_pop;
    logic                          b_emit;
    logic [7:0]                    b_byte;
    logic                          b_last;
    logic                          oq_full;
    logic [8:0]                    oq_rdata;

    // A write completes in the access phase; pready is always high.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[tlef_pkg::CFG_ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                tlef_pkg::CFG_NUMBER_NONBLANK:  r_cfg.number_nonblank  <= pwdata[0];
                tlef_pkg::CFG_NUMBER_ALL:       r_cfg.number_all       <= pwdata[0];
                tlef_pkg::CFG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= pwdata[0];
                tlef_pkg::CFG_SHOW_ENDS:        r_cfg.show_ends        <= pwdata[0];
                tlef_pkg::CFG_SHOW_TABS:        r_cfg.show_tabs        <= pwdata[0];
                tlef_pkg::CFG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Reads return the selected flag in bit 0; unmapped addresses read zero.
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            tlef_pkg::CFG_NUMBER_NONBLANK:  prdata[0] = r_cfg.number_nonblank;
            tlef_pkg::CFG_NUMBER_ALL:       prdata[0] = r_cfg.number_all;
            tlef_pkg::CFG_SQUEEZE_BLANK:    prdata[0] = r_cfg.squeeze_blank;
            tlef_pkg::CFG_SHOW_ENDS:        prdata[0] = r_cfg.show_ends;
            tlef_pkg::CFG_SHOW_TABS:        prdata[0] = r_cfg.show_tabs;
            tlef_pkg::CFG_SHOW_NONPRINTING: prdata[0] = r_cfg.show_nonprinting;
            default:                        prdata    = '0;
        endcase
    end

    // The front accepts whenever the descriptor queue has room, even for a
    // byte that turns out to be squeezed away.
    assign full   = dq_full;
    assign in_acc = push & !dq_full;

    tlef_front #(
        .LINE_DIGITS (LINE_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_acc        (in_acc),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_push       (f_push),
        .o_desc       (f_desc),
        .o_digits     (f_digits),
        .o_blank      (f_blank)
    );

    assign dq_wdata = {f_digits, f_blank, f_desc};

    tlef_queue #(
        .WIDTH (DQ_W),
        .DEPTH (DESC_DEPTH)
    ) u_desc_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (dq_wdata),
        .i_pop   (b_pop),
        .o_data  (dq_rdata),
        .o_full  (dq_full),
        .o_empty (dq_empty)
    );

    tlef_back #(
        .LINE_DIGITS (LINE_DIGITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (!dq_empty),
        .i_desc       (dq_rdata[DESC_W-1:0]),
        .i_digits     (dq_rdata[DQ_W-1 -: 4*LINE_DIGITS]),
        .i_blank      (dq_rdata[DESC_W +: LINE_DIGITS]),
        .i_out_full   (oq_full),
        .o_desc_pop   (b_pop),
        .o_emit       (b_emit),
        .o_byte       (b_byte),
        .o_last       (b_last)
    );

    // The result queue registers every output byte, so the back keeps
    // running while the consumer takes the previous transaction.
    tlef_queue #(
        .WIDTH (9),
        .DEPTH (tlef_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_emit),
        .i_data  ({b_last, b_byte}),
        .i_pop   (pop & !empty),
        .o_data  (oq_rdata),
        .o_full  (oq_full),
        .o_empty (empty)
    );

    assign o_out_byte    = oq_rdata[7:0];
    assign o_last_of_run = oq_rdata[8];

endmodule
